@@ rtl/core/fts_pkg.sv @@
package fts_pkg;

   // Kind of request, carried on tuser
   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_IDLE  = 2'd3
   } action_type;

   // Per-type counter slot; slot zero is the running total
   typedef enum logic [3:0] {
      CAT_NONE     = 4'd0,
      CAT_BEACON   = 4'd1,
      CAT_PROBE_RQ = 4'd2,
      CAT_PROBE_RS = 4'd3,
      CAT_ASSOC    = 4'd4,
      CAT_DEAUTH   = 4'd5,
      CAT_DISASSOC = 4'd6,
      CAT_OTHER    = 4'd7,
      CAT_DATA     = 4'd8
   } cat_type;

   typedef struct packed {
      logic    frame_ok;
      cat_type cat;
   } frame_evt_type;

   localparam int NUM_CNT = 9;
   localparam int CNT_W   = 32;
   localparam int HIST_W  = 16;
   localparam int POS_W   = 16;
   localparam int HPOS_W  = 6;
   localparam int IDX_W   = 6;
   localparam int REQ_W   = 16;
   localparam int CNT_VEC_W = (NUM_CNT + 1) * CNT_W;
   localparam int RSP_W   = 344;

   localparam logic [HIST_W-1:0] HIST_MAX = 16'hFFFF;
   localparam logic [POS_W-1:0]  POS_MAX  = 16'hFFFF;

   localparam logic [1:0] TYPE_MGMT = 2'd0;
   localparam logic [1:0] TYPE_DATA = 2'd2;

   localparam logic [3:0] SUB_ASSOC_RQ = 4'd0;
   localparam logic [3:0] SUB_ASSOC_RS = 4'd1;
   localparam logic [3:0] SUB_PROBE_RQ = 4'd4;
   localparam logic [3:0] SUB_PROBE_RS = 4'd5;
   localparam logic [3:0] SUB_BEACON   = 4'd8;
   localparam logic [3:0] SUB_DISASSOC = 4'd10;
   localparam logic [3:0] SUB_DEAUTH   = 4'd12;

endpackage

@@ rtl/core/fts_ram.sv @@
module fts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fts_parse.sv @@
module fts_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_en,
   input  logic [7:0]            data_byte,
   input  logic                  frame_last,
   output fts_pkg::frame_evt_type evt
);

   logic [fts_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                head0_ff, head0_in;
   logic [7:0]                head1_ff, head1_in;
   logic [15:0]               hdr_len_ff, hdr_len_in;
   logic [7:0]                ctrl_ff, ctrl_in;
   logic [7:0]                fc;
   logic [1:0]                ftype;
   logic [3:0]                fsub;

   always_comb begin
      pos_in     = pos_ff;
      head0_in   = head0_ff;
      head1_in   = head1_ff;
      hdr_len_in = hdr_len_ff;
      ctrl_in    = ctrl_ff;
      if (byte_en) begin
         priority if (pos_ff == 16'd0) begin
            head0_in = data_byte;
         end else if (pos_ff == 16'd1) begin
            head1_in = data_byte;
         end else if (pos_ff == 16'd2) begin
            hdr_len_in = {hdr_len_ff[15:8], data_byte};
         end else if (pos_ff == 16'd3) begin
            hdr_len_in = {data_byte, hdr_len_ff[7:0]};
         end else if (pos_ff == hdr_len_ff) begin
            ctrl_in = data_byte;
         end else begin
         end
         if (frame_last) begin
            pos_in = '0;
         end else if (pos_ff != fts_pkg::POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   // Short headers place the control byte inside the radiotap prefix
   always_comb begin
      priority if (hdr_len_in == 16'd0) begin
         fc = head0_in;
      end else if (hdr_len_in == 16'd1) begin
         fc = head1_in;
      end else if (hdr_len_in == 16'd2) begin
         fc = hdr_len_in[7:0];
      end else if (hdr_len_in == 16'd3) begin
         fc = hdr_len_in[15:8];
      end else begin
         fc = ctrl_in;
      end
   end

   assign ftype = fc[3:2];
   assign fsub  = fc[7:4];

   always_comb begin
      // Length is pos+1: need at least 4 bytes and header length + 2 within it
      evt.frame_ok = byte_en && frame_last && (pos_ff >= 16'd3) && (hdr_len_in < pos_ff);
      evt.cat      = fts_pkg::CAT_NONE;
      if (ftype == fts_pkg::TYPE_MGMT) begin
         unique case (fsub)
            fts_pkg::SUB_BEACON:   evt.cat = fts_pkg::CAT_BEACON;
            fts_pkg::SUB_PROBE_RQ: evt.cat = fts_pkg::CAT_PROBE_RQ;
            fts_pkg::SUB_PROBE_RS: evt.cat = fts_pkg::CAT_PROBE_RS;
            fts_pkg::SUB_ASSOC_RQ,
            fts_pkg::SUB_ASSOC_RS: evt.cat = fts_pkg::CAT_ASSOC;
            fts_pkg::SUB_DEAUTH:   evt.cat = fts_pkg::CAT_DEAUTH;
            fts_pkg::SUB_DISASSOC: evt.cat = fts_pkg::CAT_DISASSOC;
            default:               evt.cat = fts_pkg::CAT_OTHER;
         endcase
      end else if (ftype == fts_pkg::TYPE_DATA) begin
         evt.cat = fts_pkg::CAT_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         head0_ff   <= '0;
         head1_ff   <= '0;
         hdr_len_ff <= '0;
         ctrl_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         head0_ff   <= head0_in;
         head1_ff   <= head1_in;
         hdr_len_ff <= hdr_len_in;
         ctrl_ff    <= ctrl_in;
      end
   end

endmodule

@@ rtl/core/fts_hist.sv @@
module fts_hist #(
   parameter int HIST_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  fts_pkg::action_type          action,
   input  logic [fts_pkg::CNT_W-1:0]    second_count,
   input  logic [fts_pkg::IDX_W-1:0]    hist_index,
   output logic [fts_pkg::HPOS_W-1:0]   hist_pos_in,
   output logic [fts_pkg::HIST_W-1:0]   hist_value
);

   localparam int AW = $clog2(HIST_DEPTH);
   localparam int FW = $clog2(HIST_DEPTH + 1);

   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic                       tick_wr;
   logic [fts_pkg::HIST_W-1:0] sat_rate;
   logic [fts_pkg::HIST_W-1:0] rd_data;
   logic                       hit_ff, hit_in;
   logic                       fwd_ff, fwd_in;
   logic [fts_pkg::HIST_W-1:0] fwd_data_ff;
   logic [AW-1:0]              rd_addr;

   assign tick_wr  = accept && (action == fts_pkg::ACT_TICK);
   assign sat_rate = (|second_count[fts_pkg::CNT_W-1:fts_pkg::HIST_W]) ? fts_pkg::HIST_MAX
                                                                       : second_count[15:0];
   assign rd_addr  = AW'(hist_index);

   // Slots below the fill count were written since the last clear; others read as zero
   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      if (accept) begin
         unique case (action)
            fts_pkg::ACT_TICK: begin
               ptr_in = (32'(ptr_ff) == HIST_DEPTH - 1) ? '0 : ptr_ff + AW'(1);
               if (32'(fill_ff) != HIST_DEPTH) begin
                  fill_in = fill_ff + FW'(1);
               end
            end
            fts_pkg::ACT_CLEAR: begin
               ptr_in  = '0;
               fill_in = '0;
            end
            fts_pkg::ACT_BYTE, fts_pkg::ACT_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign hit_in = (32'(hist_index) < HIST_DEPTH) && (32'(hist_index) < 32'(fill_in));
   assign fwd_in = tick_wr && (ptr_ff == rd_addr);
   assign hist_pos_in = fts_pkg::HPOS_W'(ptr_in);

   fts_ram #(
      .WIDTH (fts_pkg::HIST_W),
      .DEPTH (HIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (tick_wr),
      .wr_addr (ptr_ff),
      .wr_data (sat_rate),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
         hit_ff  <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
         if (accept) begin
            hit_ff <= hit_in;
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= sat_rate;
      end
   end

   // The RAM returns the old word when a tick writes the slot being read: forward it
   assign hist_value = !hit_ff ? '0 : (fwd_ff ? fwd_data_ff : rd_data);

endmodule

@@ rtl/core/wifi_frame_type_stats_core.sv @@
// Results: an accepted request is registered into stage one, then into stage
// two, which drives rsp_tvalid; a stall holds both stages.
// Throughput: one request per cycle unless rsp_tready stalls; the history RAM
// takes one write and one read per cycle and the counters register each request.
// Reset: synchronous; clears all counters, the history fill count and
// write position, the byte assembly state and both output stages.
module wifi_frame_type_stats_core #(
   parameter int HIST_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [fts_pkg::REQ_W-1:0] req_tdata,  // data_byte[7:0], hist_index[13:8]
   input  logic                      req_tlast,  // frame_last
   input  logic [1:0]                req_tuser,  // action[1:0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // total_frames, beacon_frames, probe_requests, probe_responses, assoc_frames,
   // deauth_frames, disassoc_frames, other_mgmt_frames, data_frames,
   // frames_per_second (32 each), hist_value[335:320], hist_pos[341:336]
   output logic [fts_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int CW = fts_pkg::CNT_W;

   fts_pkg::action_type     action;
   fts_pkg::frame_evt_type  evt;
   logic                    accept;
   logic                    byte_en;
   logic [CW-1:0]           stat_ff [fts_pkg::NUM_CNT];
   logic [CW-1:0]           stat_in [fts_pkg::NUM_CNT];
   logic [CW-1:0]           second_ff, second_in;
   logic [CW-1:0]           rate_ff, rate_in;
   logic [fts_pkg::CNT_VEC_W-1:0] cnt_vec;
   logic [fts_pkg::HPOS_W-1:0]    hist_pos_in;
   logic [fts_pkg::HIST_W-1:0]    hist_value;

   logic                          s1_valid_ff;
   logic [fts_pkg::CNT_VEC_W-1:0] s1_cnt_ff;
   logic [fts_pkg::HPOS_W-1:0]    s1_pos_ff;
   logic                          s1_adv;
   logic                          s2_valid_ff;
   logic [fts_pkg::RSP_W-1:0]     s2_data_ff;

   assign action  = fts_pkg::action_type'(req_tuser);
   assign s1_adv  = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !s2_valid_ff || rsp_tready;
   assign accept  = req_tvalid && req_tready;
   assign byte_en = accept && (action == fts_pkg::ACT_BYTE);

   fts_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (byte_en),
      .data_byte  (req_tdata[7:0]),
      .frame_last (req_tlast),
      .evt        (evt)
   );

   fts_hist #(
      .HIST_DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (action),
      .second_count (second_ff),
      .hist_index   (req_tdata[13:8]),
      .hist_pos_in  (hist_pos_in),
      .hist_value   (hist_value)
   );

   always_comb begin
      stat_in   = stat_ff;
      second_in = second_ff;
      rate_in   = rate_ff;
      if (accept) begin
         unique case (action)
            fts_pkg::ACT_BYTE: begin
               if (evt.frame_ok) begin
                  stat_in[0] = stat_ff[0] + 32'd1;
                  second_in  = second_ff + 32'd1;
                  if (evt.cat != fts_pkg::CAT_NONE) begin
                     stat_in[evt.cat] = stat_ff[evt.cat] + 32'd1;
                  end
               end
            end
            fts_pkg::ACT_TICK: begin
               rate_in   = second_ff;
               second_in = '0;
            end
            fts_pkg::ACT_CLEAR: begin
               for (int k = 0; k < fts_pkg::NUM_CNT; k++) begin
                  stat_in[k] = '0;
               end
               second_in = '0;
               rate_in   = '0;
            end
            fts_pkg::ACT_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < fts_pkg::NUM_CNT; k++) begin
         cnt_vec[k*CW +: CW] = stat_in[k];
      end
      cnt_vec[fts_pkg::NUM_CNT*CW +: CW] = rate_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < fts_pkg::NUM_CNT; k++) begin
            stat_ff[k] <= '0;
         end
         second_ff   <= '0;
         rate_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         stat_ff   <= stat_in;
         second_ff <= second_in;
         rate_ff   <= rate_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   // Hold stage one while stalled; the RAM read data holds with it
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cnt_ff <= cnt_vec;
         s1_pos_ff <= hist_pos_in;
      end
      if (s1_adv) begin
         s2_data_ff <= {2'b00, s1_pos_ff, hist_value, s1_cnt_ff};
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_data_ff;

endmodule

@@ tb/sv/fts_stats_mon.sv @@
`timescale 1ns / 100ps

module fts_stats_mon
   import fts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // data_byte[7:0], hist_index[13:8]
   input  logic              req_tlast,   // frame_last
   input  logic [1:0]        req_tuser,   // action[1:0]
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,   // counters (32 each), hist_value, hist_pos
   output int                mismatches,
   output int                outstanding
);

   localparam int HIST_DEPTH  = 64;
   localparam int TOTAL_SLOT  = 0;

   // Layout of one result, lowest bits last
   typedef struct packed {
      logic [1:0]                  pad;
      logic [HPOS_W-1:0]           hist_pos;
      logic [HIST_W-1:0]           hist_value;
      logic [NUM_CNT:0][CNT_W-1:0] counts;   // total first, frames_per_second last
   } stats_word_type;

   logic [CNT_W-1:0]  tally [NUM_CNT];
   logic [CNT_W-1:0]  rate_latched;
   logic [CNT_W-1:0]  second_count;
   logic [HIST_W-1:0] rate_hist [HIST_DEPTH];
   logic [HPOS_W-1:0] hist_ptr;
   logic [POS_W-1:0]  byte_pos;
   logic [7:0]        head_byte [2];
   logic [15:0]       hdr_len;
   logic [7:0]        ctrl_byte;
   stats_word_type    stats_fifo [$];

   string count_name [NUM_CNT+1] = '{
      "total_frames", "beacon_frames", "probe_requests", "probe_responses",
      "assoc_frames", "deauth_frames", "disassoc_frames", "other_mgmt_frames",
      "data_frames", "frames_per_second"
   };

   function automatic void clear_stats();
      foreach (tally[i]) tally[i] = '0;
      rate_latched = '0;
      second_count = '0;
      foreach (rate_hist[i]) rate_hist[i] = '0;
      hist_ptr = '0;
   endfunction

   function automatic stats_word_type update_stats(action_type act, logic [7:0] b, logic last,
                                                   logic [IDX_W-1:0] hidx);
      stats_word_type res;
      int unsigned len;
      logic [7:0]  fc;
      cat_type     cat;
      case (act)
         ACT_BYTE: begin
            if (byte_pos < 2) head_byte[byte_pos[0]] = b;
            else if (byte_pos == 2) hdr_len[7:0] = b;
            else if (byte_pos == 3) hdr_len[15:8] = b;
            else if (byte_pos == hdr_len) ctrl_byte = b;
            if (last) begin
               len = 32'(byte_pos) + 1;
               if (len >= 4 && 32'(hdr_len) + 2 <= len) begin
                  // short header: control byte falls inside the radiotap preamble
                  case (hdr_len)
                     16'd0:   fc = head_byte[0];
                     16'd1:   fc = head_byte[1];
                     16'd2:   fc = hdr_len[7:0];
                     16'd3:   fc = hdr_len[15:8];
                     default: fc = ctrl_byte;
                  endcase
                  cat = CAT_NONE;
                  if (fc[3:2] == TYPE_MGMT) begin
                     case (fc[7:4])
                        SUB_BEACON:                 cat = CAT_BEACON;
                        SUB_PROBE_RQ:               cat = CAT_PROBE_RQ;
                        SUB_PROBE_RS:               cat = CAT_PROBE_RS;
                        SUB_ASSOC_RQ, SUB_ASSOC_RS: cat = CAT_ASSOC;
                        SUB_DEAUTH:                 cat = CAT_DEAUTH;
                        SUB_DISASSOC:               cat = CAT_DISASSOC;
                        default:                    cat = CAT_OTHER;
                     endcase
                  end else if (fc[3:2] == TYPE_DATA) begin
                     cat = CAT_DATA;
                  end
                  tally[TOTAL_SLOT] = tally[TOTAL_SLOT] + 32'd1;
                  second_count = second_count + 32'd1;
                  if (cat != CAT_NONE) tally[cat] = tally[cat] + 32'd1;
               end
               byte_pos = '0;
            end else if (byte_pos != POS_MAX) begin
               byte_pos = byte_pos + 16'd1;
            end
         end
         ACT_TICK: begin
            rate_latched = second_count;
            second_count = '0;
            rate_hist[hist_ptr] = (rate_latched > 32'(HIST_MAX)) ? HIST_MAX
                                                                : rate_latched[HIST_W-1:0];
            hist_ptr = hist_ptr + 6'd1;
         end
         ACT_CLEAR: clear_stats();
         default: ;
      endcase
      res.pad = '0;
      for (int k = 0; k < NUM_CNT; k++) res.counts[k] = tally[k];
      res.counts[NUM_CNT] = rate_latched;
      res.hist_value = rate_hist[hidx];
      res.hist_pos = hist_ptr;
      return res;
   endfunction

   task automatic flag_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      stats_word_type got;
      stats_word_type want;
      if (reset) begin
         clear_stats();
         byte_pos = '0;
         head_byte[0] = '0;
         head_byte[1] = '0;
         hdr_len = '0;
         ctrl_byte = '0;
         stats_fifo.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (stats_fifo.size() == 0) begin
               mismatches++;
               $error("result arrived with no request outstanding");
            end else begin
               want = stats_fifo.pop_front();
               for (int k = 0; k <= NUM_CNT; k++)
                  flag_field(count_name[k], want.counts[k], got.counts[k]);
               flag_field("hist_value", 32'(want.hist_value), 32'(got.hist_value));
               flag_field("hist_pos", 32'(want.hist_pos), 32'(got.hist_pos));
            end
         end
         if (req_tvalid && req_tready)
            stats_fifo.push_back(update_stats(action_type'(req_tuser), req_tdata[7:0],
                                              req_tlast, req_tdata[13:8]));
      end
      outstanding <= stats_fifo.size();
   end

endmodule

@@ tb/sv/tb_wifi_frame_type_stats_core.sv @@
`timescale 1ns / 100ps

module tb_wifi_frame_type_stats_core;
   import fts_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_ITEMS    = 900;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam longint TIMEOUT_NS  = 2_000_000;

   localparam logic [1:0] TYPE_CTRL = 2'd1;
   localparam logic [1:0] TYPE_RSVD = 2'd3;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tlast  = 1'b0;
   logic [1:0]       req_tuser  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               mismatches;
   int               outstanding;

   int hold_requests = 0;
   int items_sent    = 0;
   int snd_run       = 0;
   bit snd_calm      = 1'b0;
   int rcv_run       = 0;
   bit rcv_calm      = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   wifi_frame_type_stats_core #(
      .HIST_DEPTH (64)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fts_stats_mon u_stats_mon (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Idle in segments: some segments run flat out, others idle before each request
   function automatic int next_gap(inout int run, inout bit calm);
      if (run == 0) begin
         run = $urandom_range(1, 40);
         calm = ($urandom_range(0, 3) == 0);
      end
      run--;
      return calm ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic send_req(action_type act, logic [7:0] b, logic last, logic [IDX_W-1:0] hidx);
      int gap;
      gap = next_gap(snd_run, snd_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, hidx, b};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (act != ACT_IDLE) items_sent++;
   endtask

   task automatic send_stray();
      int         pick;
      action_type act;
      pick = $urandom_range(0, 7);
      act = (pick < 4) ? ACT_TICK : ((pick < 5) ? ACT_CLEAR : ACT_IDLE);
      send_req(act, 8'($urandom), 1'($urandom), 6'($urandom_range(0, 63)));
   endtask

   task automatic send_frame(int unsigned len, logic [15:0] hlen, logic [7:0] fc, bit interject);
      logic [7:0] b;
      for (int unsigned pos = 0; pos < len; pos++) begin
         if (pos == 2) b = hlen[7:0];
         else if (pos == 3) b = hlen[15:8];
         else if (pos == hlen) b = fc;
         else b = 8'($urandom);
         if (interject && $urandom_range(0, 24) == 0) send_stray();
         send_req(ACT_BYTE, b, pos == len - 1, 6'($urandom_range(0, 63)));
      end
   endtask

   task automatic send_random_frame();
      logic [15:0] hlen;
      int unsigned len;
      logic [1:0]  ftype;
      logic [3:0]  sub;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) hlen = 16'($urandom_range(0, 3));
      else if (pick == 1) hlen = 16'($urandom);
      else hlen = 16'($urandom_range(4, 24));
      // truncated frames stay short even when the header claims a huge length
      if (hlen > 64 || $urandom_range(0, 7) == 0) begin
         len = $urandom_range(1, 12);
      end else begin
         len = 32'(hlen) + 2 + $urandom_range(0, 6);
         if (len < 4) len = 4;
      end
      pick = $urandom_range(0, 5);
      if (pick < 3) ftype = TYPE_MGMT;
      else if (pick == 3) ftype = TYPE_DATA;
      else if (pick == 4) ftype = TYPE_CTRL;
      else ftype = TYPE_RSVD;
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 6))
            0:       sub = SUB_ASSOC_RQ;
            1:       sub = SUB_ASSOC_RS;
            2:       sub = SUB_PROBE_RQ;
            3:       sub = SUB_PROBE_RS;
            4:       sub = SUB_BEACON;
            5:       sub = SUB_DISASSOC;
            default: sub = SUB_DEAUTH;
         endcase
      end else begin
         sub = 4'($urandom);
      end
      send_frame(len, hlen, {sub, ftype, 2'($urandom)}, 1'b1);
   endtask

   // Drop the offer and hold until every result has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Result side
   initial begin
      int gap;
      int holds_done;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < hold_requests) begin
            gap = HOLD_CYCLES;
            holds_done++;
         end else begin
            gap = next_gap(rcv_run, rcv_calm);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[wifi_frame_type_stats_core] ERROR");
      $finish;
   end

   initial begin
      int  target;
      int  pick;
      bit  held;
      bit  paused;
      held = 1'b0;
      paused = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every action, short headers, a truncated frame
      send_req(ACT_IDLE, 8'hFF, 1'b1, 6'd63);
      send_req(ACT_TICK, 8'h00, 1'b0, 6'd0);
      send_frame(4, 16'd0, 8'h80, 1'b0);
      send_frame(5, 16'd1, 8'h08, 1'b0);
      send_frame(4, 16'd2, 8'hD0, 1'b0);
      send_frame(5, 16'd3, 8'hC4, 1'b0);
      send_frame(3, 16'd0, 8'hC0, 1'b0);
      send_req(ACT_TICK, 8'hFF, 1'b1, 6'd1);
      send_req(ACT_CLEAR, 8'hFF, 1'b1, 6'd63);

      // random: mostly well-formed frames, with ticks, clears and stray bytes between
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_random_frame();
         end else if (pick < 17) begin
            send_stray();
         end else begin
            repeat ($urandom_range(1, 6))
               send_req(ACT_BYTE, 8'($urandom), $urandom_range(0, 3) == 0,
                        6'($urandom_range(0, 63)));
         end
         if (!held && items_sent > target - RANDOM_ITEMS + 400) begin
            hold_requests++;
            held = 1'b1;
         end
         if (!paused && items_sent > target - RANDOM_ITEMS + 750) begin
            wait_idle();
            paused = 1'b1;
         end
      end

      // latch a rate, read back every history slot, then wrap the write position
      wait_idle();
      send_req(ACT_TICK, 8'($urandom), 1'($urandom), 6'($urandom_range(0, 63)));
      for (int i = 0; i < 64; i++) send_req(ACT_IDLE, 8'($urandom), 1'($urandom), 6'(i));
      repeat (70) begin
         if ($urandom_range(0, 3) == 0) send_frame(4, 16'd0, 8'($urandom), 1'b0);
         send_req(ACT_TICK, 8'($urandom), 1'($urandom), 6'($urandom_range(0, 63)));
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[wifi_frame_type_stats_core] OK");
      else
         $display("[wifi_frame_type_stats_core] ERROR");
      $finish;
   end

endmodule
